### rtl/dbsps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbsps_pkg
// Shared types and constants of the dual-branch short preamble synchronizer.
// ----------------------------------------------------------------------------
package dbsps_pkg;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'b01,
    MODE_COPY   = 2'b10
  } mode_t;

  localparam int ADDR_WIDTH = 4;
  localparam int DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_PLATEAU_LEN = 2'd1,
    REG_MIN_GAP     = 2'd2,
    REG_FRAME_LEN   = 2'd3
  } reg_index_t;

  localparam int THRESHOLD_WIDTH = 17;
  localparam int PLATEAU_WIDTH   = 8;
  localparam int COUNT_WIDTH     = 16;
  localparam int METRIC_WIDTH    = 16;
  localparam int OFFSET_WIDTH    = 16;

  localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET   = 17'd18350;
  localparam logic [PLATEAU_WIDTH-1:0]   PLATEAU_LEN_RESET = 8'd2;
  localparam logic [COUNT_WIDTH-1:0]     MIN_GAP_RESET     = 16'd480;
  localparam logic [COUNT_WIDTH-1:0]     FRAME_LEN_RESET   = 16'(540 * 80);

  localparam int GUARD_BITS = 8;
  localparam int CFO_SHIFT  = 4;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam int MAX_CORDIC_STAGES = 24;

  // Arctangent of 2^-k, a full turn being 2^32.
  localparam logic [31:0] ATAN_TURN [MAX_CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage
`default_nettype wire

### rtl/dbsps_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbsps_if
// Request channels of the synchronizer: sample input and derotated output.
// ----------------------------------------------------------------------------
interface dbsps_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                                    valid;
  logic                                    ready;
  logic signed [SAMPLE_WIDTH-1:0]          branch_a_i;
  logic signed [SAMPLE_WIDTH-1:0]          branch_a_q;
  logic signed [SAMPLE_WIDTH-1:0]          branch_b_i;
  logic signed [SAMPLE_WIDTH-1:0]          branch_b_q;
  logic signed [SAMPLE_WIDTH-1:0]          acorr_a_i;
  logic signed [SAMPLE_WIDTH-1:0]          acorr_a_q;
  logic signed [SAMPLE_WIDTH-1:0]          acorr_b_i;
  logic signed [SAMPLE_WIDTH-1:0]          acorr_b_q;
  logic [dbsps_pkg::METRIC_WIDTH-1:0]      metric_a;
  logic [dbsps_pkg::METRIC_WIDTH-1:0]      metric_b;

  modport source (
    output valid, branch_a_i, branch_a_q, branch_b_i, branch_b_q,
           acorr_a_i, acorr_a_q, acorr_b_i, acorr_b_q, metric_a, metric_b,
    input  ready
  );
  modport sink (
    input  valid, branch_a_i, branch_a_q, branch_b_i, branch_b_q,
           acorr_a_i, acorr_a_q, acorr_b_i, acorr_b_q, metric_a, metric_b,
    output ready
  );
endinterface

interface dbsps_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                                    valid;
  logic                                    ready;
  logic signed [SAMPLE_WIDTH-1:0]          out_a_i;
  logic signed [SAMPLE_WIDTH-1:0]          out_a_q;
  logic signed [SAMPLE_WIDTH-1:0]          out_b_i;
  logic signed [SAMPLE_WIDTH-1:0]          out_b_q;
  logic                                    frame_start;
  logic signed [dbsps_pkg::OFFSET_WIDTH-1:0] cfo_a;
  logic signed [dbsps_pkg::OFFSET_WIDTH-1:0] cfo_b;

  modport source (
    output valid, out_a_i, out_a_q, out_b_i, out_b_q, frame_start, cfo_a, cfo_b,
    input  ready
  );
  modport sink (
    input  valid, out_a_i, out_a_q, out_b_i, out_b_q, frame_start, cfo_a, cfo_b,
    output ready
  );
endinterface
`default_nettype wire

### rtl/dbsps_vec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbsps_vec
// Pipelined vectoring CORDIC lane: angle of one autocorrelation, scaled to a
// per-sample frequency offset.
// ----------------------------------------------------------------------------
module dbsps_vec #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int PHASE_WIDTH   = 20,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     en,
  input  wire logic signed [SAMPLE_WIDTH-1:0]           x_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]           y_in,
  output logic signed [dbsps_pkg::OFFSET_WIDTH-1:0]     offset
);

  localparam int XW = SAMPLE_WIDTH + dbsps_pkg::GUARD_BITS + 3;
  localparam int AW = PHASE_WIDTH + 1;
  localparam logic signed [PHASE_WIDTH-1:0] A_MIN = {1'b1, {(PHASE_WIDTH-1){1'b0}}};

  logic signed [XW-1:0] vx [CORDIC_STAGES+1];
  logic signed [XW-1:0] vy [CORDIC_STAGES+1];
  logic [31:0]          vz [CORDIC_STAGES+1];
  logic                 vzero [CORDIC_STAGES+1];

  logic signed [XW-1:0] xs, ys;
  logic [31:0]          zr;
  logic signed [PHASE_WIDTH-1:0] a_raw;
  logic signed [AW-1:0] a, q;
  logic signed [31:0]   q32;
  logic signed [dbsps_pkg::OFFSET_WIDTH-1:0] offset_next;

  assign xs = XW'(x_in) <<< dbsps_pkg::GUARD_BITS;
  assign ys = XW'(y_in) <<< dbsps_pkg::GUARD_BITS;

  // Fold the left half plane onto the right one before the iterations.
  always_ff @(posedge clk) begin
    if (en) begin
      vzero[0] <= (x_in == '0) && (y_in == '0);
      if (xs < 0) begin
        vx[0] <= -xs;
        vy[0] <= -ys;
        vz[0] <= 32'h8000_0000;
      end else begin
        vx[0] <= xs;
        vy[0] <= ys;
        vz[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        vzero[k+1] <= vzero[k];
        if (vy[k] > 0) begin
          vx[k+1] <= vx[k] + (vy[k] >>> k);
          vy[k+1] <= vy[k] - (vx[k] >>> k);
          vz[k+1] <= vz[k] + dbsps_pkg::ATAN_TURN[k];
        end else begin
          vx[k+1] <= vx[k] - (vy[k] >>> k);
          vy[k+1] <= vy[k] + (vx[k] >>> k);
          vz[k+1] <= vz[k] - dbsps_pkg::ATAN_TURN[k];
        end
      end
    end
  end

  // Round to the phase width, map the negative half turn to the positive one,
  // divide by the symbol spacing toward zero and saturate.
  always_comb begin
    zr    = vz[CORDIC_STAGES] + (32'd1 << (31 - PHASE_WIDTH));
    a_raw = $signed(zr[31 -: PHASE_WIDTH]);
    a     = (a_raw == A_MIN) ? -AW'(a_raw) : AW'(a_raw);
    if (a[AW-1]) begin
      q = (a + AW'((1 << dbsps_pkg::CFO_SHIFT) - 1)) >>> dbsps_pkg::CFO_SHIFT;
    end else begin
      q = a >>> dbsps_pkg::CFO_SHIFT;
    end
    q32 = 32'(q);
    if (vzero[CORDIC_STAGES]) begin
      offset_next = '0;
    end else if (q32 > 32767) begin
      offset_next = 16'sh7fff;
    end else if (q32 < -32768) begin
      offset_next = 16'sh8000;
    end else begin
      offset_next = q32[dbsps_pkg::OFFSET_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offset <= offset_next;
    end
  end

endmodule
`default_nettype wire

### rtl/dbsps_rot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbsps_rot
// Pipelined rotation CORDIC lane: derotates one complex sample by a phase,
// with gain correction, rounding and saturation.
// ----------------------------------------------------------------------------
module dbsps_rot #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int PHASE_WIDTH   = 20,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y_in,
  input  wire logic [PHASE_WIDTH-1:0]         phase,
  output logic signed [SAMPLE_WIDTH-1:0]      x_out,
  output logic signed [SAMPLE_WIDTH-1:0]      y_out
);

  localparam int XW = SAMPLE_WIDTH + dbsps_pkg::GUARD_BITS + 3;
  localparam int PM = XW + 18;
  localparam logic signed [16:0]   GAIN_S = {1'b0, dbsps_pkg::INV_GAIN_Q16};
  localparam logic signed [PM-1:0] RND    = PM'(1) <<< (15 + dbsps_pkg::GUARD_BITS);
  localparam logic signed [PM-1:0] SMAX   = PM'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [PM-1:0] SMIN   = -SMAX - PM'(1);

  logic signed [XW-1:0] vx [CORDIC_STAGES+1];
  logic signed [XW-1:0] vy [CORDIC_STAGES+1];
  logic signed [31:0]   vz [CORDIC_STAGES+1];
  logic signed [PM-1:0] px, py;

  logic [31:0]          r, r_off;
  logic [1:0]           quad;
  logic signed [XW-1:0] xs, ys;
  logic signed [PM-1:0] shx, shy;

  // Rotating by the negated phase: pull the angle into the first quadrant
  // around zero and swap the sample by the matching multiple of a quarter turn.
  always_comb begin
    r     = 32'd0 - {phase, {(32 - PHASE_WIDTH){1'b0}}};
    r_off = r + 32'h2000_0000;
    quad  = r_off[31:30];
    xs    = XW'(x_in) <<< dbsps_pkg::GUARD_BITS;
    ys    = XW'(y_in) <<< dbsps_pkg::GUARD_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vz[0] <= $signed(r - {quad, 30'd0});
      case (quad)
        2'd1: begin
          vx[0] <= -ys;
          vy[0] <= xs;
        end
        2'd2: begin
          vx[0] <= -xs;
          vy[0] <= -ys;
        end
        2'd3: begin
          vx[0] <= ys;
          vy[0] <= -xs;
        end
        default: begin
          vx[0] <= xs;
          vy[0] <= ys;
        end
      endcase
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (vz[k] >= 0) begin
          vx[k+1] <= vx[k] - (vy[k] >>> k);
          vy[k+1] <= vy[k] + (vx[k] >>> k);
          vz[k+1] <= vz[k] - $signed(dbsps_pkg::ATAN_TURN[k]);
        end else begin
          vx[k+1] <= vx[k] + (vy[k] >>> k);
          vy[k+1] <= vy[k] - (vx[k] >>> k);
          vz[k+1] <= vz[k] + $signed(dbsps_pkg::ATAN_TURN[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px <= vx[CORDIC_STAGES] * GAIN_S + RND;
      py <= vy[CORDIC_STAGES] * GAIN_S + RND;
    end
  end

  assign shx = px >>> (16 + dbsps_pkg::GUARD_BITS);
  assign shy = py >>> (16 + dbsps_pkg::GUARD_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      if (shx > SMAX) begin
        x_out <= SMAX[SAMPLE_WIDTH-1:0];
      end else if (shx < SMIN) begin
        x_out <= SMIN[SAMPLE_WIDTH-1:0];
      end else begin
        x_out <= shx[SAMPLE_WIDTH-1:0];
      end
      if (shy > SMAX) begin
        y_out <= SMAX[SAMPLE_WIDTH-1:0];
      end else if (shy < SMIN) begin
        y_out <= SMIN[SAMPLE_WIDTH-1:0];
      end else begin
        y_out <= shy[SAMPLE_WIDTH-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/dual_branch_short_preamble_sync.sv
`default_nettype none
// Throughput: one request per cycle; the whole pipeline advances whenever the
// output register is empty or taken. Only the triggering search sample emits.
// Reset: synchronous, active high; sets the mode to search, clears counters,
// offsets, phases, pipeline valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
// dual_branch_short_preamble_sync
// Plateau detection, offset estimation per branch and per-branch derotation.
// ----------------------------------------------------------------------------
module dual_branch_short_preamble_sync #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int PHASE_WIDTH   = 20,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  dbsps_in_if.sink                                   din,
  dbsps_out_if.source                                dout,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [dbsps_pkg::ADDR_WIDTH-1:0]      paddr,
  input  wire logic [dbsps_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [dbsps_pkg::DATA_WIDTH-1:0]           prdata,
  output logic                                       pready
);

  localparam int VL = CORDIC_STAGES + 3;
  localparam int RL = CORDIC_STAGES + 3;
  localparam int OW = dbsps_pkg::OFFSET_WIDTH;

  // Configuration registers.
  logic [dbsps_pkg::THRESHOLD_WIDTH-1:0] threshold;
  logic [dbsps_pkg::PLATEAU_WIDTH-1:0]   plateau_len;
  logic [dbsps_pkg::COUNT_WIDTH-1:0]     min_gap;
  logic [dbsps_pkg::COUNT_WIDTH-1:0]     frame_len;
  logic                                  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= dbsps_pkg::THRESHOLD_RESET;
      plateau_len <= dbsps_pkg::PLATEAU_LEN_RESET;
      min_gap     <= dbsps_pkg::MIN_GAP_RESET;
      frame_len   <= dbsps_pkg::FRAME_LEN_RESET;
    end else if (cfg_write) begin
      case (dbsps_pkg::reg_index_t'(paddr[3:2]))
        dbsps_pkg::REG_THRESHOLD:   threshold   <= pwdata[dbsps_pkg::THRESHOLD_WIDTH-1:0];
        dbsps_pkg::REG_PLATEAU_LEN: plateau_len <= pwdata[dbsps_pkg::PLATEAU_WIDTH-1:0];
        dbsps_pkg::REG_MIN_GAP:     min_gap     <= pwdata[dbsps_pkg::COUNT_WIDTH-1:0];
        dbsps_pkg::REG_FRAME_LEN:   frame_len   <= pwdata[dbsps_pkg::COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (dbsps_pkg::reg_index_t'(paddr[3:2]))
      dbsps_pkg::REG_THRESHOLD:   prdata = 32'(threshold);
      dbsps_pkg::REG_PLATEAU_LEN: prdata = 32'(plateau_len);
      dbsps_pkg::REG_MIN_GAP:     prdata = 32'(min_gap);
      dbsps_pkg::REG_FRAME_LEN:   prdata = 32'(frame_len);
      default:                    prdata = '0;
    endcase
  end

  // Pipeline enable: everything moves when the output register can take data.
  logic en, accept;
  assign en        = !dout.valid || dout.ready;
  assign din.ready = en && !rst;
  assign accept    = din.valid && din.ready;

  // Plateau and frame control, decided when a request is taken.
  dbsps_pkg::mode_t                    mode, mode_next;
  logic [dbsps_pkg::PLATEAU_WIDTH-1:0] plateau_count, plateau_count_next;
  logic [dbsps_pkg::COUNT_WIDTH-1:0]   copy_count, copy_count_next;
  logic                                above, start, emit;

  always_comb begin
    above              = (17'(din.metric_a) + 17'(din.metric_b)) > threshold;
    start              = 1'b0;
    emit               = 1'b1;
    plateau_count_next = plateau_count;
    copy_count_next    = copy_count;
    mode_next          = mode;
    if (mode == dbsps_pkg::MODE_SEARCH) begin
      if (!above) begin
        plateau_count_next = '0;
        emit = 1'b0;
      end else if (plateau_count < plateau_len) begin
        plateau_count_next = plateau_count + 1'b1;
        emit = 1'b0;
      end else begin
        start = 1'b1;
      end
    end else if (above) begin
      if (plateau_count < plateau_len) begin
        plateau_count_next = plateau_count + 1'b1;
      end else if (copy_count > min_gap) begin
        start = 1'b1;
      end
    end else begin
      plateau_count_next = '0;
    end
    // The trigger sample counts as the first sample of the new plateau.
    if (start) begin
      plateau_count_next = (plateau_len != '0) ? 8'd1 : 8'd0;
    end
    if (emit) begin
      copy_count_next = (start ? '0 : copy_count) + 1'b1;
      mode_next = (copy_count_next >= frame_len) ? dbsps_pkg::MODE_SEARCH
                                                  : dbsps_pkg::MODE_COPY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= dbsps_pkg::MODE_SEARCH;
      plateau_count <= '0;
      copy_count    <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      plateau_count <= plateau_count_next;
      copy_count    <= copy_count_next;
    end
  end

  // Sample line that runs beside the offset estimators.
  logic                           dv [VL];
  logic                           ds [VL];
  logic signed [SAMPLE_WIDTH-1:0] d_ai [VL];
  logic signed [SAMPLE_WIDTH-1:0] d_aq [VL];
  logic signed [SAMPLE_WIDTH-1:0] d_bi [VL];
  logic signed [SAMPLE_WIDTH-1:0] d_bq [VL];
  logic signed [SAMPLE_WIDTH-1:0] c_ai, c_aq, c_bi, c_bq;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VL; i++) begin
        dv[i] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= accept && emit;
      for (int i = 1; i < VL; i++) begin
        dv[i] <= dv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0]   <= start;
      d_ai[0] <= din.branch_a_i;
      d_aq[0] <= din.branch_a_q;
      d_bi[0] <= din.branch_b_i;
      d_bq[0] <= din.branch_b_q;
      c_ai    <= din.acorr_a_i;
      c_aq    <= din.acorr_a_q;
      c_bi    <= din.acorr_b_i;
      c_bq    <= din.acorr_b_q;
      for (int i = 1; i < VL; i++) begin
        ds[i]   <= ds[i-1];
        d_ai[i] <= d_ai[i-1];
        d_aq[i] <= d_aq[i-1];
        d_bi[i] <= d_bi[i-1];
        d_bq[i] <= d_bq[i-1];
      end
    end
  end

  logic signed [OW-1:0] est_a, est_b;

  dbsps_vec #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_vec_a (
    .clk   (clk),
    .en    (en),
    .x_in  (c_ai),
    .y_in  (c_aq),
    .offset(est_a)
  );

  dbsps_vec #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_vec_b (
    .clk   (clk),
    .en    (en),
    .x_in  (c_bi),
    .y_in  (c_bq),
    .offset(est_b)
  );

  // Merge: latch new offsets on a frame start and run the phase accumulators.
  logic signed [OW-1:0]    offset_a, offset_b, off_a_cur, off_b_cur;
  logic [PHASE_WIDTH-1:0]  phase_a_acc, phase_b_acc, ph_a_use, ph_b_use;

  always_comb begin
    off_a_cur = ds[VL-1] ? est_a : offset_a;
    off_b_cur = ds[VL-1] ? est_b : offset_b;
    ph_a_use  = ds[VL-1] ? '0 : phase_a_acc;
    ph_b_use  = ds[VL-1] ? '0 : phase_b_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_a    <= '0;
      offset_b    <= '0;
      phase_a_acc <= '0;
      phase_b_acc <= '0;
    end else if (en && dv[VL-1]) begin
      offset_a    <= off_a_cur;
      offset_b    <= off_b_cur;
      phase_a_acc <= ph_a_use + PHASE_WIDTH'(off_a_cur);
      phase_b_acc <= ph_b_use + PHASE_WIDTH'(off_b_cur);
    end
  end

  // Result side line beside the derotators.
  logic                 rv [RL];
  logic                 rs [RL];
  logic signed [OW-1:0] r_ca [RL];
  logic signed [OW-1:0] r_cb [RL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RL; i++) begin
        rv[i] <= 1'b0;
      end
    end else if (en) begin
      rv[0] <= dv[VL-1];
      for (int i = 1; i < RL; i++) begin
        rv[i] <= rv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0]   <= ds[VL-1];
      r_ca[0] <= off_a_cur;
      r_cb[0] <= off_b_cur;
      for (int i = 1; i < RL; i++) begin
        rs[i]   <= rs[i-1];
        r_ca[i] <= r_ca[i-1];
        r_cb[i] <= r_cb[i-1];
      end
    end
  end

  dbsps_rot #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_rot_a (
    .clk  (clk),
    .en   (en),
    .x_in (d_ai[VL-1]),
    .y_in (d_aq[VL-1]),
    .phase(ph_a_use),
    .x_out(dout.out_a_i),
    .y_out(dout.out_a_q)
  );

  dbsps_rot #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_rot_b (
    .clk  (clk),
    .en   (en),
    .x_in (d_bi[VL-1]),
    .y_in (d_bq[VL-1]),
    .phase(ph_b_use),
    .x_out(dout.out_b_i),
    .y_out(dout.out_b_q)
  );

  assign dout.valid       = rv[RL-1];
  assign dout.frame_start = rs[RL-1];
  assign dout.cfo_a       = r_ca[RL-1];
  assign dout.cfo_b       = r_cb[RL-1];

endmodule
`default_nettype wire
